// File: hw/rtl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int DEPTH_DEFAULT    = 16;
    localparam int TAG_BITS_DEFAULT = 32;

    localparam int PRIO_W     = 2;
    localparam int IO_TAG_W   = 32;
    localparam int OCC_W      = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;
    localparam int S_TUSER_W  = 1;
    localparam int M_TUSER_W  = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SERVE  = 1'b1;

    localparam logic [PRIO_W-1:0] PRIO_LOWEST = 2'd1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occupied;
    } cell_cmd_t;

endpackage

// File: hw/rtl/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts toward either neighbor.
module spq_cell #(
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEFAULT
) (
    input  logic                      clk,
    input  spq_pkg::cell_cmd_t        cmd,
    input  logic [spq_pkg::PRIO_W-1:0] new_prio,
    input  logic [TAG_BITS-1:0]       new_tag,
    input  logic [spq_pkg::PRIO_W-1:0] left_prio,
    input  logic [TAG_BITS-1:0]       left_tag,
    input  logic [spq_pkg::PRIO_W-1:0] right_prio,
    input  logic [TAG_BITS-1:0]       right_tag,
    output logic [spq_pkg::PRIO_W-1:0] prio,
    output logic [TAG_BITS-1:0]       tag,
    output logic                      beat
);

    logic [spq_pkg::PRIO_W-1:0] prio_reg;
    logic [spq_pkg::PRIO_W-1:0] prio_next;
    logic [TAG_BITS-1:0]        tag_reg;
    logic [TAG_BITS-1:0]        tag_next;

    // The new entry belongs at or before this slot when the slot is empty or
    // holds a strictly lower priority.
    assign beat = !cmd.occupied || (new_prio > prio_reg);
    assign prio = prio_reg;
    assign tag  = tag_reg;

    always_comb
    begin
        prio_next = prio_reg;
        tag_next  = tag_reg;
        unique case (cmd.op)
            spq_pkg::CELL_HOLD:
            begin
                prio_next = prio_reg;
                tag_next  = tag_reg;
            end
            spq_pkg::CELL_LOAD_NEW:
            begin
                prio_next = new_prio;
                tag_next  = new_tag;
            end
            spq_pkg::CELL_FROM_LEFT:
            begin
                prio_next = left_prio;
                tag_next  = left_tag;
            end
            spq_pkg::CELL_FROM_RIGHT:
            begin
                prio_next = right_prio;
                tag_next  = right_tag;
            end
            default:
            begin
                prio_next = prio_reg;
                tag_next  = tag_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

endmodule

// File: hw/rtl/stable_priority_queue.sv
// Top level of the stable priority queue: a row of entry cells and the result register.
//
// The slave channel carries one command word per handshake. tuser selects the
// command: 0 inserts an entry with the priority and tag in tdata, 1 serves the
// head entry. Each accepted word yields exactly one result word on the master
// channel, with the status in tuser and the served priority, served tag and
// occupancy in tdata. Entries are kept sorted in a row of DEPTH cells, highest
// priority at the head and arrival order within one level. Every cell compares
// the new priority with its own in parallel, and an insert or a serve shifts the
// row by one slot. The result word is registered on acceptance and appears in the
// next cycle. Throughput is one word per cycle while the receiver keeps up; the
// result register is the only stage between the channels. When the receiver
// stalls, the pending result holds and tready falls until it is taken. Reset
// empties the queue and the result register; cell contents are not cleared,
// since only occupied slots are ever read.
// Serving an empty queue reports status 2; inserting into a full queue drops
// the entry and reports status 3.
module stable_priority_queue #(
    parameter int DEPTH    = spq_pkg::DEPTH_DEFAULT,
    parameter int TAG_BITS = spq_pkg::TAG_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: priority_req[1:0], tag[33:2], zero fill [39:34].
    input  logic [spq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: op[0].
    input  logic [spq_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: served_priority[1:0], served_tag[33:2], occupancy[38:34], zero fill [39].
    output logic [spq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // tuser: status[1:0].
    output logic [spq_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                       accept;
    logic                       op;
    logic [spq_pkg::PRIO_W-1:0] req_prio;
    logic [spq_pkg::PRIO_W-1:0] new_prio;
    logic [TAG_BITS-1:0]        new_tag;
    logic                       is_full;
    logic                       is_empty;
    logic                       do_insert;
    logic                       do_serve;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [spq_pkg::PRIO_W-1:0] cell_prio [DEPTH];
    logic [TAG_BITS-1:0]        cell_tag  [DEPTH];
    logic [DEPTH-1:0]           cell_beat;

    logic                        out_valid_reg;
    spq_pkg::status_t            status_reg;
    spq_pkg::status_t            status_next;
    logic [spq_pkg::PRIO_W-1:0]  served_prio_reg;
    logic [spq_pkg::PRIO_W-1:0]  served_prio_next;
    logic [spq_pkg::IO_TAG_W-1:0] served_tag_reg;
    logic [spq_pkg::IO_TAG_W-1:0] served_tag_next;
    logic [spq_pkg::OCC_W-1:0]   occ_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign op       = s_axis_tuser[0];
    assign req_prio = s_axis_tdata[1:0];
    assign new_prio = (req_prio == '0) ? spq_pkg::PRIO_LOWEST : req_prio;
    assign new_tag  = TAG_BITS'(s_axis_tdata[33:2]);

    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign do_insert = accept && (op == spq_pkg::OP_INSERT) && !is_full;
    assign do_serve  = accept && (op == spq_pkg::OP_SERVE) && !is_empty;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_pkg::cell_cmd_t         cmd;
        logic [spq_pkg::PRIO_W-1:0] left_prio;
        logic [TAG_BITS-1:0]        left_tag;
        logic [spq_pkg::PRIO_W-1:0] right_prio;
        logic [TAG_BITS-1:0]        right_tag;
        logic                       left_beat;

        if (i == 0)
        begin : g_head
            assign left_prio = new_prio;
            assign left_tag  = new_tag;
            assign left_beat = 1'b0;
        end
        else
        begin : g_body
            assign left_prio = cell_prio[i-1];
            assign left_tag  = cell_tag[i-1];
            assign left_beat = cell_beat[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_prio = cell_prio[i];
            assign right_tag  = cell_tag[i];
        end
        else
        begin : g_inner
            assign right_prio = cell_prio[i+1];
            assign right_tag  = cell_tag[i+1];
        end

        always_comb
        begin
            cmd.occupied = (count_reg > CNT_W'(i));
            cmd.op       = spq_pkg::CELL_HOLD;
            if (do_insert)
            begin
                if (left_beat)
                begin
                    cmd.op = spq_pkg::CELL_FROM_LEFT;
                end
                else if (cell_beat[i])
                begin
                    cmd.op = spq_pkg::CELL_LOAD_NEW;
                end
            end
            else if (do_serve && (i < DEPTH - 1))
            begin
                cmd.op = spq_pkg::CELL_FROM_RIGHT;
            end
        end

        spq_cell #(
            .TAG_BITS(TAG_BITS)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .new_prio  (new_prio),
            .new_tag   (new_tag),
            .left_prio (left_prio),
            .left_tag  (left_tag),
            .right_prio(right_prio),
            .right_tag (right_tag),
            .prio      (cell_prio[i]),
            .tag       (cell_tag[i]),
            .beat      (cell_beat[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_serve)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        served_prio_next = '0;
        served_tag_next  = '0;
        if (op == spq_pkg::OP_INSERT)
        begin
            status_next = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
        end
        else if (is_empty)
        begin
            status_next = spq_pkg::ST_EMPTY;
        end
        else
        begin
            status_next      = spq_pkg::ST_SERVED;
            served_prio_next = cell_prio[0];
            served_tag_next  = spq_pkg::IO_TAG_W'(cell_tag[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            served_prio_reg <= served_prio_next;
            served_tag_reg  <= served_tag_next;
            occ_reg         <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {1'b0, occ_reg, served_tag_reg, served_prio_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue holds more entries than it has cells");

    a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_prio[0] >= cell_prio[1]))
        else $error("head entry is ranked below its successor");

    a_serve_result: assert property (@(posedge clk) disable iff (!rst_n)
        do_serve |=> (m_axis_tvalid && (status_reg == spq_pkg::ST_SERVED)
            && (served_prio_reg != '0)))
        else $error("serve of a held entry did not report it");

    a_occ_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (occ_reg == spq_pkg::OCC_W'(count_reg)))
        else $error("reported occupancy differs from the entry count");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for stable_priority_queue with random stream traffic.
module tb_top;

    localparam int ITEM_COUNT  = 1550;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        spq_pkg::status_t             status;
        logic [spq_pkg::PRIO_W-1:0]   prio;
        logic [spq_pkg::IO_TAG_W-1:0] tag;
        logic [spq_pkg::OCC_W-1:0]    occ;
    } spq_result_t;

    class spq_scoreboard;
        logic [spq_pkg::PRIO_W-1:0]   held_prio[$];
        logic [spq_pkg::IO_TAG_W-1:0] held_tag[$];
        spq_result_t                  expected_results[$];
        int                           errors = 0;

        function void flag_mismatch(string what);
            errors++;
            if (errors <= 10)
            begin
                $display("%0t: %s", $realtime, what);
            end
        endfunction

        function void note_command(logic op, logic [spq_pkg::PRIO_W-1:0] prio_req,
                                   logic [spq_pkg::IO_TAG_W-1:0] tag);
            spq_result_t                r;
            int                         pos;
            logic [spq_pkg::PRIO_W-1:0] level;
            r = '0;
            if (op == spq_pkg::OP_INSERT)
            begin
                if (held_prio.size() >= spq_pkg::DEPTH_DEFAULT)
                begin
                    r.status = spq_pkg::ST_FULL;
                end
                else
                begin
                    level = (prio_req == '0) ? spq_pkg::PRIO_LOWEST : prio_req;
                    pos = 0;
                    while (pos < held_prio.size() && level <= held_prio[pos])
                    begin
                        pos++;
                    end
                    held_prio.insert(pos, level);
                    held_tag.insert(pos, tag);
                    r.status = spq_pkg::ST_INSERTED;
                end
            end
            else if (held_prio.size() == 0)
            begin
                r.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                r.status = spq_pkg::ST_SERVED;
                r.prio   = held_prio.pop_front();
                r.tag    = held_tag.pop_front();
            end
            r.occ = spq_pkg::OCC_W'(held_prio.size());
            expected_results.push_back(r);
        endfunction

        function void check_result(spq_result_t got);
            spq_result_t want;
            if (expected_results.size() == 0)
            begin
                flag_mismatch($sformatf("result word with nothing expected: status %0d",
                                        got.status));
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.prio !== want.prio ||
                got.tag !== want.tag || got.occ !== want.occ)
            begin
                flag_mismatch($sformatf(
                    "mismatch: expected status %0d prio %0d tag %h occ %0d, got %0d %0d %h %0d",
                    want.status, want.prio, want.tag, want.occ,
                    got.status, got.prio, got.tag, got.occ));
            end
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [spq_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [spq_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [spq_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [spq_pkg::M_TUSER_W-1:0] m_axis_tuser;

    spq_scoreboard sb;
    bit            no_idle = 1'b0;
    int            quiet_cycles = 0;

    stable_priority_queue i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_command(logic op, logic [spq_pkg::PRIO_W-1:0] prio_req,
                                logic [spq_pkg::IO_TAG_W-1:0] tag);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(spq_pkg::S_TDATA_W - spq_pkg::PRIO_W - spq_pkg::IO_TAG_W){1'b0}},
                          tag, prio_req};
        s_axis_tuser  <= op;
        do
        begin
            @(posedge clk);
        end
        while (!(s_axis_tvalid && s_axis_tready));
        sb.note_command(op, prio_req, tag);
    endtask

    initial
    begin
        int                           sent;
        int                           run_len;
        int                           insert_pct;
        logic                         op;
        logic [spq_pkg::IO_TAG_W-1:0] tag;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_command(spq_pkg::OP_SERVE, 2'd3, 32'hFFFF_FFFF);
        send_command(spq_pkg::OP_INSERT, 2'd1, 32'h0000_0000);
        send_command(spq_pkg::OP_INSERT, 2'd3, 32'hFFFF_FFFF);
        send_command(spq_pkg::OP_INSERT, 2'd0, 32'h0000_0001);
        send_command(spq_pkg::OP_INSERT, 2'd2, 32'h8000_0000);
        send_command(spq_pkg::OP_INSERT, 2'd3, 32'h5555_5555);
        for (int i = 0; i < 12; i++)
        begin
            send_command(spq_pkg::OP_INSERT, spq_pkg::PRIO_W'(i % 4), 32'hA5A5_0000 | i);
        end
        for (int i = 0; i < 6; i++)
        begin
            send_command(spq_pkg::OP_SERVE, spq_pkg::PRIO_W'($urandom_range(0, 3)),
                         $urandom());
        end
        sent = 24;

        while (sent < ITEM_COUNT)
        begin
            run_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0: insert_pct = 15;
                1: insert_pct = 50;
                default: insert_pct = 85;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < run_len && sent < ITEM_COUNT; k++)
            begin
                op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT
                                                          : spq_pkg::OP_SERVE;
                case ($urandom_range(0, 9))
                    0: tag = '0;
                    1: tag = '1;
                    default: tag = $urandom();
                endcase
                send_command(op, spq_pkg::PRIO_W'($urandom_range(0, 3)), tag);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (sb.pending_count() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        int          stall;
        spq_result_t got;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = spq_pkg::status_t'(m_axis_tuser);
                got.prio   = m_axis_tdata[spq_pkg::PRIO_W-1:0];
                got.tag    = m_axis_tdata[spq_pkg::PRIO_W +: spq_pkg::IO_TAG_W];
                got.occ    = m_axis_tdata[spq_pkg::PRIO_W + spq_pkg::IO_TAG_W +: spq_pkg::OCC_W];
                sb.check_result(got);
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
